### sv/fsp_pkg.sv
package fsp_pkg;

   // Field widths of the sample, bin and configuration data.
   localparam int SAMPLE_W = 16;
   localparam int DATA_W   = 24;
   localparam int MAG_W    = 23;
   localparam int BIN_W    = 6;
   localparam int RATE_W   = 20;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int WIDE_W   = 2 * DATA_W + 2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam data_type DATA_MAX = 24'sh7FFFFF;
   localparam data_type DATA_MIN = -24'sh800000;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   // Configuration register indexes.
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_DC_REMOVE   = 2'd0;
   localparam csr_index_type CSR_WINDOW      = 2'd1;
   localparam csr_index_type CSR_SAMPLE_RATE = 2'd2;

   localparam logic [RATE_W-1:0] RATE_RESET = 20'd10000;

   // Constants of the fixed-point cosine series used to build the tables.
   localparam longint ONE_Q28 = 64'sd1 <<< 28;
   localparam longint unsigned TWO_PI_Q54 = 64'h01921FB54442D184;
   localparam longint unsigned TAYLOR_DEN [1:12] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

   // Four-term Blackman-Harris weights, scaled by 100000.
   localparam longint BH_A0 = 64'sd35875;
   localparam longint BH_A1 = 64'sd48829;
   localparam longint BH_A2 = 64'sd14128;
   localparam longint BH_A3 = 64'sd1168;
   localparam longint BH_SCALE = 64'sd100000;

   // Saturate a wide intermediate to the 24-bit signed data range.
   function automatic data_type sat_data(input wide_type v);
      data_type r;
      if (v > wide_type'(DATA_MAX)) begin
         r = DATA_MAX;
      end else if (v < wide_type'(DATA_MIN)) begin
         r = DATA_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### sv/fft_spectrum_peak_core.sv
// Frame spectrum core: takes POINTS samples at one item per cycle, then processes the frame.
// Processing uses one shared 24x24 multiplier and a sample memory with one read and one
// write port. Bins then leave one at a time, each once the output register is free;
// the next frame is taken once the last bin is accepted.
// Synchronous active-high reset clears the sequencer, output valid, peak tracking and the
// configuration registers (mean removal on, window on, sample rate 10000 Hz).
module fft_spectrum_peak_core #(
   parameter int POINTS     = 64,
   parameter int COEF_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [fsp_pkg::SAMPLE_W-1:0]  req_sample_real,
   input  logic signed [fsp_pkg::SAMPLE_W-1:0]  req_sample_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fsp_pkg::BIN_W-1:0]            rsp_bin_index,
   output logic signed [fsp_pkg::DATA_W-1:0]    rsp_bin_real,
   output logic signed [fsp_pkg::DATA_W-1:0]    rsp_bin_imag,
   output logic [fsp_pkg::MAG_W-1:0]            rsp_bin_magnitude,
   output logic [fsp_pkg::BIN_W-1:0]            rsp_peak_bin,
   output logic [fsp_pkg::RATE_W-1:0]           rsp_peak_frequency,
   output logic                                 rsp_last_bin,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  fsp_pkg::csr_index_type               csr_index,
   input  logic [fsp_pkg::RATE_W-1:0]           csr_write_data
);

   localparam int LG    = $clog2(POINTS);
   localparam int HALF  = POINTS / 2;
   localparam int DM1   = POINTS - 1;
   localparam int FRAC  = COEF_WIDTH - 1;
   localparam int ST_W  = $clog2(LG);
   localparam int SUM_W = fsp_pkg::SAMPLE_W + LG;
   localparam int DW    = fsp_pkg::DATA_W;
   localparam int MEM_W = 2 * DW;
   localparam longint CMAX = (64'sd1 <<< FRAC) - 64'sd1;
   localparam longint WIN_DEN = fsp_pkg::BH_SCALE <<< (28 - FRAC);
   localparam fsp_pkg::wide_type HALF_LSB = fsp_pkg::wide_type'(64'sd1 <<< (FRAC - 1));
   localparam logic [ST_W:0] LG_M1 = (ST_W + 1)'(LG - 1);
   localparam logic [fsp_pkg::PROD_W-1:0] SQRT_TOP = fsp_pkg::PROD_W'(1) << (fsp_pkg::PROD_W - 2);

   // cos(2*pi*m/d) in Q28, d being POINTS or POINTS-1; evaluated at elaboration only.
   function automatic longint cos_q28(input longint unsigned m_in, input logic by_pm1);
      longint unsigned m;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      if (by_pm1) begin
         m = m_in % DM1;
         if (2 * m > DM1) m = DM1 - m;
         x = (m * fsp_pkg::TWO_PI_Q54 / DM1) >> 26;
      end else begin
         m = m_in % POINTS;
         if (2 * m > POINTS) m = POINTS - m;
         x = (m * fsp_pkg::TWO_PI_Q54 / POINTS) >> 26;
      end
      x2 = (x * x) >> 28;
      term = fsp_pkg::ONE_Q28;
      sum = fsp_pkg::ONE_Q28;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * x2) >> 28) / fsp_pkg::TAYLOR_DEN[k];
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return sum;
   endfunction

   // Round a Q28 value to Q1.FRAC, clamped to the symmetric coefficient range.
   function automatic logic [COEF_WIDTH-1:0] to_coef(input longint q);
      longint v;
      v = (q + (64'sd1 <<< (27 - FRAC))) >>> (28 - FRAC);
      if (v > CMAX) v = CMAX;
      if (v < -CMAX) v = -CMAX;
      return COEF_WIDTH'(v);
   endfunction

   function automatic logic [HALF-1:0][COEF_WIDTH-1:0] build_twiddle(input logic sine);
      logic [HALF-1:0][COEF_WIDTH-1:0] t;
      for (int k = 0; k < HALF; k++) begin
         if (sine) t[k] = to_coef(cos_q28((POINTS / 4 + POINTS - k) % POINTS, 1'b0));
         else t[k] = to_coef(cos_q28(k, 1'b0));
      end
      return t;
   endfunction

   function automatic logic [HALF-1:0][COEF_WIDTH-1:0] build_window();
      logic [HALF-1:0][COEF_WIDTH-1:0] t;
      longint num;
      for (int k = 0; k < HALF; k++) begin
         num = fsp_pkg::BH_A0 * fsp_pkg::ONE_Q28 - fsp_pkg::BH_A1 * cos_q28(k, 1'b1)
             + fsp_pkg::BH_A2 * cos_q28(2 * k, 1'b1) - fsp_pkg::BH_A3 * cos_q28(3 * k, 1'b1);
         if (num < 0) num = 0;
         num = (num + WIN_DEN / 2) / WIN_DEN;
         if (num > CMAX) num = CMAX;
         t[k] = COEF_WIDTH'(num);
      end
      return t;
   endfunction

   localparam logic [HALF-1:0][COEF_WIDTH-1:0] TW_COS = build_twiddle(1'b0);
   localparam logic [HALF-1:0][COEF_WIDTH-1:0] TW_SIN = build_twiddle(1'b1);
   localparam logic [HALF-1:0][COEF_WIDTH-1:0] WIN_W  = build_window();

   // Sequencer state codes.
   localparam logic [4:0] ST_LOAD    = 5'd0;
   localparam logic [4:0] ST_PRE_RD  = 5'd1;
   localparam logic [4:0] ST_PRE_DC  = 5'd2;
   localparam logic [4:0] ST_PRE_MUL = 5'd3;
   localparam logic [4:0] ST_PRE_WR  = 5'd4;
   localparam logic [4:0] ST_BF_RDB  = 5'd5;
   localparam logic [4:0] ST_BF_RDA  = 5'd6;
   localparam logic [4:0] ST_BF_M0   = 5'd7;
   localparam logic [4:0] ST_BF_M1   = 5'd8;
   localparam logic [4:0] ST_BF_M2   = 5'd9;
   localparam logic [4:0] ST_BF_M3   = 5'd10;
   localparam logic [4:0] ST_BF_M4   = 5'd11;
   localparam logic [4:0] ST_BF_WB   = 5'd12;
   localparam logic [4:0] ST_BF_WA   = 5'd13;
   localparam logic [4:0] ST_EM_RD   = 5'd14;
   localparam logic [4:0] ST_EM_SQ0  = 5'd15;
   localparam logic [4:0] ST_EM_SQ1  = 5'd16;
   localparam logic [4:0] ST_EM_SQ2  = 5'd17;
   localparam logic [4:0] ST_EM_SQRT = 5'd18;
   localparam logic [4:0] ST_EM_OUT  = 5'd19;

   // Control and configuration registers.
   logic [4:0]                  state_ff, state_in;
   logic [LG-1:0]               cnt_ff, cnt_in;
   logic [ST_W-1:0]             st_ff, st_in;
   logic                        dc_en_ff, dc_en_in;
   logic                        win_en_ff, win_en_in;
   logic [fsp_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [fsp_pkg::MAG_W-1:0]   best_mag_ff, best_mag_in;
   logic [fsp_pkg::BIN_W-1:0]   best_bin_ff, best_bin_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   fsp_pkg::data_type           a_re_ff, a_re_in, a_im_ff, a_im_in;
   fsp_pkg::data_type           b_re_ff, b_re_in, b_im_ff, b_im_in;
   fsp_pkg::prod_type           prod_ff, prod_in;
   fsp_pkg::wide_type           acc_ff, acc_in;
   logic signed [DW+1:0]        tr_ff, tr_in, ti_ff, ti_in;
   logic [fsp_pkg::PROD_W-1:0]  sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [fsp_pkg::BIN_W+fsp_pkg::RATE_W-1:0] freq_prod_ff;
   logic [fsp_pkg::BIN_W-1:0]   out_index_ff, out_index_in;
   fsp_pkg::data_type           out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic [fsp_pkg::MAG_W-1:0]   out_mag_ff, out_mag_in;
   logic                        out_last_ff, out_last_in;

   // Sample memory: real part in the upper half, imaginary part in the lower half.
   logic [MEM_W-1:0]            store_mem [POINTS];
   logic [MEM_W-1:0]            rd_data_ff;
   logic [LG-1:0]               rd_addr;
   logic                        mem_we;
   logic [LG-1:0]               wr_addr;
   logic [MEM_W-1:0]            wr_data;

   // Shared multiplier operands.
   fsp_pkg::data_type           mul_a, mul_b;

   fsp_pkg::data_type           rd_re, rd_im;
   logic [LG-1:0]               cnt_rev;
   logic [LG-1:0]               win_t;
   logic [LG-2:0]               bf_c, bf_mask, bf_j, bf_grp, bf_tw;
   logic [LG-1:0]               bf_k, bf_kh;
   fsp_pkg::data_type           tw_re, tw_sn;
   logic [fsp_pkg::PROD_W-1:0]  sq_trial;
   logic                        out_free;
   logic                        req_fire;
   logic signed [SUM_W-1:0]     mean;

   assign rd_re = fsp_pkg::data_type'(rd_data_ff[MEM_W-1:DW]);
   assign rd_im = fsp_pkg::data_type'(rd_data_ff[DW-1:0]);
   assign mean  = sum_ff >>> LG;

   // Loading writes each sample to its bit-reversed address.
   always_comb begin
      for (int b = 0; b < LG; b++) begin
         cnt_rev[b] = cnt_ff[LG-1-b];
      end
   end

   // Window weight of the sample held at the current address; the window is symmetric.
   assign win_t = cnt_rev[LG-1] ? ~cnt_rev : cnt_rev;

   // Butterfly addressing for stage st_ff and butterfly count bf_c.
   assign bf_c    = cnt_ff[LG-2:0];
   assign bf_mask = ((LG-1)'(1) << st_ff) - (LG-1)'(1);
   assign bf_j    = bf_c & bf_mask;
   assign bf_grp  = bf_c >> st_ff;
   assign bf_k    = (LG'(bf_grp) << ((ST_W + 1)'(st_ff) + (ST_W + 1)'(1))) | LG'(bf_j);
   assign bf_kh   = bf_k | (LG'(1) << st_ff);
   assign bf_tw   = bf_j << (LG_M1 - (ST_W + 1)'(st_ff));
   assign tw_re   = fsp_pkg::data_type'(signed'(TW_COS[bf_tw]));
   assign tw_sn   = fsp_pkg::data_type'(signed'(TW_SIN[bf_tw]));

   assign sq_trial = sq_r_ff + sq_bit_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // A new frame waits until the last bin of the previous one has left, so the peak
   // fields stay put while that item waits.
   assign req_ready = (state_ff == ST_LOAD) && !rsp_valid_ff;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = a_re_ff;
      mul_b = a_re_ff;
      unique case (state_ff)
         ST_PRE_MUL: begin
            mul_a = a_re_ff;
            mul_b = fsp_pkg::data_type'({1'b0, WIN_W[win_t[LG-2:0]]});
         end
         ST_BF_M0: begin
            mul_a = b_re_ff;
            mul_b = tw_re;
         end
         ST_BF_M1: begin
            mul_a = b_im_ff;
            mul_b = tw_sn;
         end
         ST_BF_M2: begin
            mul_a = b_im_ff;
            mul_b = tw_re;
         end
         ST_BF_M3: begin
            mul_a = b_re_ff;
            mul_b = tw_sn;
         end
         ST_EM_SQ0: begin
            mul_a = rd_re;
            mul_b = rd_re;
         end
         ST_EM_SQ1: begin
            mul_a = a_im_ff;
            mul_b = a_im_ff;
         end
         default: begin
            mul_a = a_re_ff;
            mul_b = a_re_ff;
         end
      endcase
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      dc_en_in     = dc_en_ff;
      win_en_in    = win_en_ff;
      rate_in      = rate_ff;
      best_mag_in  = best_mag_ff;
      best_bin_in  = best_bin_ff;
      rsp_valid_in = rsp_valid_ff;
      sum_in       = sum_ff;
      a_re_in      = a_re_ff;
      a_im_in      = a_im_ff;
      b_re_in      = b_re_ff;
      b_im_in      = b_im_ff;
      prod_in      = mul_a * mul_b;
      acc_in       = acc_ff;
      tr_in        = tr_ff;
      ti_in        = ti_ff;
      sq_v_in      = sq_v_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      out_index_in = out_index_ff;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      out_mag_in   = out_mag_ff;
      out_last_in  = out_last_ff;
      rd_addr      = cnt_ff;
      mem_we       = 1'b0;
      wr_addr      = cnt_rev;
      wr_data      = {fsp_pkg::data_type'(req_sample_real), fsp_pkg::data_type'(req_sample_imag)};

      // A delivered item frees the output register.
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      // Configuration writes; unknown indexes are ignored.
      if (csr_valid) begin
         unique case (csr_index)
            fsp_pkg::CSR_DC_REMOVE:   dc_en_in = csr_write_data[0];
            fsp_pkg::CSR_WINDOW:      win_en_in = csr_write_data[0];
            fsp_pkg::CSR_SAMPLE_RATE: rate_in = csr_write_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               mem_we = 1'b1;
               if (cnt_ff == '0) sum_in = SUM_W'(req_sample_real);
               else sum_in = sum_ff + SUM_W'(req_sample_real);
               cnt_in = cnt_ff + LG'(1);
               if (cnt_ff == LG'(DM1)) state_in = ST_PRE_RD;
            end
         end

         // Mean removal and window, one address at a time.
         ST_PRE_RD: state_in = ST_PRE_DC;
         ST_PRE_DC: begin
            if (dc_en_ff) begin
               a_re_in = fsp_pkg::sat_data(fsp_pkg::wide_type'(rd_re)
                                           - fsp_pkg::wide_type'(mean));
            end else begin
               a_re_in = rd_re;
            end
            a_im_in = rd_im;
            state_in = ST_PRE_MUL;
         end
         ST_PRE_MUL: state_in = ST_PRE_WR;
         ST_PRE_WR: begin
            mem_we = 1'b1;
            wr_addr = cnt_ff;
            if (win_en_ff) begin
               wr_data = {fsp_pkg::sat_data((fsp_pkg::wide_type'(prod_ff) + HALF_LSB) >>> FRAC),
                          a_im_ff};
            end else begin
               wr_data = {a_re_ff, a_im_ff};
            end
            cnt_in = cnt_ff + LG'(1);
            if (cnt_ff == LG'(DM1)) begin
               st_in = '0;
               state_in = ST_BF_RDB;
            end else begin
               state_in = ST_PRE_RD;
            end
         end

         // Radix-2 butterfly: fetch b then a, four products, two write-backs.
         ST_BF_RDB: begin
            rd_addr = bf_kh;
            state_in = ST_BF_RDA;
         end
         ST_BF_RDA: begin
            rd_addr = bf_k;
            b_re_in = rd_re;
            b_im_in = rd_im;
            state_in = ST_BF_M0;
         end
         ST_BF_M0: begin
            a_re_in = rd_re;
            a_im_in = rd_im;
            state_in = ST_BF_M1;
         end
         ST_BF_M1: begin
            acc_in = fsp_pkg::wide_type'(prod_ff);
            state_in = ST_BF_M2;
         end
         ST_BF_M2: begin
            tr_in = (DW + 2)'((acc_ff + fsp_pkg::wide_type'(prod_ff) + HALF_LSB) >>> FRAC);
            state_in = ST_BF_M3;
         end
         ST_BF_M3: begin
            acc_in = fsp_pkg::wide_type'(prod_ff);
            state_in = ST_BF_M4;
         end
         ST_BF_M4: begin
            ti_in = (DW + 2)'((acc_ff - fsp_pkg::wide_type'(prod_ff) + HALF_LSB) >>> FRAC);
            state_in = ST_BF_WB;
         end
         ST_BF_WB: begin
            mem_we = 1'b1;
            wr_addr = bf_kh;
            wr_data = {fsp_pkg::sat_data(fsp_pkg::wide_type'(a_re_ff) - fsp_pkg::wide_type'(tr_ff)),
                       fsp_pkg::sat_data(fsp_pkg::wide_type'(a_im_ff) - fsp_pkg::wide_type'(ti_ff))};
            state_in = ST_BF_WA;
         end
         ST_BF_WA: begin
            mem_we = 1'b1;
            wr_addr = bf_k;
            wr_data = {fsp_pkg::sat_data(fsp_pkg::wide_type'(a_re_ff) + fsp_pkg::wide_type'(tr_ff)),
                       fsp_pkg::sat_data(fsp_pkg::wide_type'(a_im_ff) + fsp_pkg::wide_type'(ti_ff))};
            if (bf_c == '1) begin
               cnt_in = '0;
               if (st_ff == ST_W'(LG - 1)) begin
                  best_mag_in = '0;
                  best_bin_in = '0;
                  state_in = ST_EM_RD;
               end else begin
                  st_in = st_ff + ST_W'(1);
                  state_in = ST_BF_RDB;
               end
            end else begin
               cnt_in = cnt_ff + LG'(1);
               state_in = ST_BF_RDB;
            end
         end

         // Emit: squares, bit-by-bit square root, then the output register.
         ST_EM_RD: state_in = ST_EM_SQ0;
         ST_EM_SQ0: begin
            b_re_in = rd_re;
            a_im_in = rd_im;
            state_in = ST_EM_SQ1;
         end
         ST_EM_SQ1: begin
            acc_in = fsp_pkg::wide_type'(prod_ff);
            state_in = ST_EM_SQ2;
         end
         ST_EM_SQ2: begin
            sq_v_in = fsp_pkg::PROD_W'(acc_ff + fsp_pkg::wide_type'(prod_ff));
            sq_r_in = '0;
            sq_bit_in = SQRT_TOP;
            state_in = ST_EM_SQRT;
         end
         ST_EM_SQRT: begin
            if (sq_v_ff >= sq_trial) begin
               sq_v_in = sq_v_ff - sq_trial;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_index_in = fsp_pkg::BIN_W'(cnt_ff);
               out_re_in = b_re_ff;
               out_im_in = a_im_ff;
               if (sq_r_ff > fsp_pkg::PROD_W'(fsp_pkg::MAG_MAX)) out_mag_in = fsp_pkg::MAG_MAX;
               else out_mag_in = sq_r_ff[fsp_pkg::MAG_W-1:0];
               out_last_in = (cnt_ff == LG'(DM1));
               if (cnt_ff != '0 && cnt_ff <= LG'(HALF) && out_mag_in > best_mag_ff) begin
                  best_mag_in = out_mag_in;
                  best_bin_in = fsp_pkg::BIN_W'(cnt_ff);
               end
               cnt_in = cnt_ff + LG'(1);
               if (cnt_ff == LG'(DM1)) state_in = ST_LOAD;
               else state_in = ST_EM_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         st_ff        <= '0;
         dc_en_ff     <= 1'b1;
         win_en_ff    <= 1'b1;
         rate_ff      <= fsp_pkg::RATE_RESET;
         best_mag_ff  <= '0;
         best_bin_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         st_ff        <= st_in;
         dc_en_ff     <= dc_en_in;
         win_en_ff    <= win_en_in;
         rate_ff      <= rate_in;
         best_mag_ff  <= best_mag_in;
         best_bin_ff  <= best_bin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      a_re_ff      <= a_re_in;
      a_im_ff      <= a_im_in;
      b_re_ff      <= b_re_in;
      b_im_ff      <= b_im_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      tr_ff        <= tr_in;
      ti_ff        <= ti_in;
      sq_v_ff      <= sq_v_in;
      sq_r_ff      <= sq_r_in;
      sq_bit_ff    <= sq_bit_in;
      freq_prod_ff <= best_bin_ff * rate_ff;
      out_index_ff <= out_index_in;
      out_re_ff    <= out_re_in;
      out_im_ff    <= out_im_in;
      out_mag_ff   <= out_mag_in;
      out_last_ff  <= out_last_in;
   end

   // Sample memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[wr_addr] <= wr_data;
      rd_data_ff <= store_mem[rd_addr];
   end

   // Result ports; peak fields only on the last bin.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_index      = out_index_ff;
   assign rsp_bin_real       = out_re_ff;
   assign rsp_bin_imag       = out_im_ff;
   assign rsp_bin_magnitude  = out_mag_ff;
   assign rsp_last_bin       = out_last_ff;
   assign rsp_peak_bin       = out_last_ff ? best_bin_ff : '0;
   assign rsp_peak_frequency = out_last_ff ? freq_prod_ff[LG +: fsp_pkg::RATE_W] : '0;

   // The last item of a frame always carries the top bin number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |-> rsp_bin_index == fsp_pkg::BIN_W'(DM1))
      else $error("last bin flag on a bin other than the top one");

   // The peak lies in the lower half of the spectrum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |-> rsp_peak_bin <= fsp_pkg::BIN_W'(HALF))
      else $error("peak bin outside the searched range");

   // Peak fields stay zero on every other bin.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_bin |-> rsp_peak_bin == '0 && rsp_peak_frequency == '0)
      else $error("peak fields set on a bin that is not the last");

endmodule
